>>> hw/rtl/assert_macros.svh
// assertion macros included by the deque top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge of clock, masked while reset is high
`define ASSERT_IMPL(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication checked on every rising edge of clock
`define ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

>>> hw/rtl/deq_pkg.sv
// types and constants shared by the deque controller, datapath and top level
package deq_pkg;

   localparam int OP_W = 3;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK       = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } st_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic read;
      logic load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

>>> hw/rtl/deq_ctrl.sv
// controller state machine: accept, read both ends, load the result register
module deq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  deq_pkg::status_type  status,
   output deq_pkg::cmd_type     cmd
);
   import deq_pkg::*;

   st_type state_ff;
   st_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            // wait here until the result register can take the new result
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/deq_dpath.sv
// deque datapath: ring memory, front pointer, entry count and result register
module deq_dpath #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   parameter int AW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  deq_pkg::cmd_type           cmd,
   output deq_pkg::status_type        status,
   input  logic [deq_pkg::OP_W-1:0]   op,
   input  logic [WIDTH-1:0]           data_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [WIDTH-1:0]           front_value,
   output logic [WIDTH-1:0]           back_value,
   output logic [CW-1:0]              entry_count,
   output logic                       underflow,
   output logic                       overflow
);
   import deq_pkg::*;

   localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
   localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(DEPTH);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

   logic [WIDTH-1:0] mem [DEPTH];

   logic [AW-1:0]    front_ff, front_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             under_ff, under_in;
   logic             over_ff, over_in;
   logic [WIDTH-1:0] rd_front_ff, rd_back_ff;
   logic             rsp_valid_ff;
   logic [WIDTH-1:0] out_front_ff, out_back_ff;
   logic [CW-1:0]    out_count_ff;
   logic             out_under_ff, out_over_ff;

   logic             full, empty;
   logic [AW-1:0]    front_dec, front_inc;
   logic [AW:0]      tail_sum, back_sum;
   logic [AW-1:0]    tail_idx, back_idx, back_off;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);

   assign front_dec = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
   assign front_inc = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;

   // slot after the last entry; count is below DEPTH whenever it is used
   assign tail_sum = {1'b0, front_ff} + (AW+1)'(count_ff);
   assign tail_idx = (tail_sum >= DEPTH_EXT) ? AW'(tail_sum - DEPTH_EXT) : tail_sum[AW-1:0];

   // last occupied slot, kept in range when the queue is empty
   assign back_off = empty ? '0 : AW'(count_ff - 1'b1);
   assign back_sum = {1'b0, front_ff} + {1'b0, back_off};
   assign back_idx = (back_sum >= DEPTH_EXT) ? AW'(back_sum - DEPTH_EXT) : back_sum[AW-1:0];

   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      under_in = 1'b0;
      over_in  = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = tail_idx;
      case (op_type'(op))
         OP_PUSH_FRONT: begin
            if (full) begin
               over_in = 1'b1;
            end else begin
               front_in = front_dec;
               wr_en    = 1'b1;
               wr_addr  = front_dec;
               count_in = count_ff + 1'b1;
            end
         end
         OP_PUSH_BACK: begin
            if (full) begin
               over_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               under_in = 1'b1;
            end else begin
               front_in = front_inc;
               count_in = count_ff - 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               under_in = 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            // peek and unused codes leave everything as it is
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (cmd.accept) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         under_ff <= under_in;
         over_ff  <= over_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && wr_en) begin
         mem[wr_addr] <= data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_front_ff <= mem[front_ff];
         rd_back_ff  <= mem[back_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_front_ff <= empty ? '0 : rd_front_ff;
         out_back_ff  <= empty ? '0 : rd_back_ff;
         out_count_ff <= count_ff;
         out_under_ff <= under_ff;
         out_over_ff  <= over_ff;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign front_value = out_front_ff;
   assign back_value  = out_back_ff;
   assign entry_count = out_count_ff;
   assign underflow   = out_under_ff;
   assign overflow    = out_over_ff;

endmodule

>>> hw/rtl/double_ended_queue_core.sv
// bounded double-ended queue top level: controller, datapath and stream ports
//
//  channel   direction  ports                         payload
//  request   in         req_tvalid/tready/tdata/tuser  tuser operation, tdata data_in
//  response  out        rsp_tvalid/tready/tdata        front, back, count, underflow, overflow
//
// a request runs through accept, read and load: the accept edge updates pointer, count and
// ring, the read step reads front and back from the two ring read ports, and the load
// step loads the result register; a new request is taken the cycle after.
// the result register holds a finished result while the next request runs;
// a stalled response only holds the load step. reset clears pointer, count
// and valid; ring contents are not cleared.
`include "assert_macros.svh"

module double_ended_queue_core #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // data_in, zero filled to whole bytes
   input  logic [((WIDTH + 7) / 8) * 8 - 1:0]     req_tdata,
   // operation
   input  logic [deq_pkg::OP_W-1:0]               req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // front_value, back_value, entry_count, underflow, overflow, zero filled
   output logic [((2 * WIDTH + $clog2(DEPTH + 1) + 2 + 7) / 8) * 8 - 1:0] rsp_tdata
);
   import deq_pkg::*;

   localparam int CW       = $clog2(DEPTH + 1);
   localparam int RSP_BITS = 2 * WIDTH + CW + 2;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   cmd_type          cmd;
   status_type       status;
   logic [WIDTH-1:0] front_value, back_value;
   logic [CW-1:0]    entry_count;
   logic             underflow, overflow;

   deq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   deq_dpath #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .op          (req_tuser),
      .data_in     (req_tdata[WIDTH-1:0]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .front_value (front_value),
      .back_value  (back_value),
      .entry_count (entry_count),
      .underflow   (underflow),
      .overflow    (overflow)
   );

   assign rsp_tdata = RSP_W'({overflow, underflow, entry_count, back_value, front_value});

   `ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "request taken while busy")
   `ASSERT_IMPL(a_count_bound, rsp_tvalid, entry_count <= CW'(DEPTH), "entry count above depth")
   `ASSERT_IMPL(a_empty_reads_zero, rsp_tvalid && entry_count == '0, front_value == '0 && back_value == '0, "empty queue shows data")
   `ASSERT_IMPL(a_single_flag, rsp_tvalid, !(underflow && overflow), "underflow and overflow together")

endmodule
